@@ hdl/ftsg_pkg.sv @@
package ftsg_pkg;

  localparam int unsigned CoordLimitDefault = 1024;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ColorW = 8;

  // Request codes
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqSpan = 1'b1;

  // Split divider: numerator 2|p|+d needs 22 bits, divisor 2d needs 11 bits
  localparam int unsigned DivNumW = 22;
  localparam int unsigned DivDenW = 11;
  localparam int unsigned DivCntW = 5;

  // One DDA edge: current point, remainders over 2n, slopes, steps left
  typedef struct packed {
    logic [CoordW-1:0]        x;
    logic [CoordW-1:0]        y;
    logic [CoordW:0]          rx;
    logic [CoordW:0]          ry;
    logic signed [CoordW:0]   dx;
    logic [CoordW-1:0]        dy;
    logic [CoordW-1:0]        n;
    logic [CoordW-1:0]        rem;
    logic                     exh;
  } edge_t;

  function automatic edge_t edge_init(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                                      logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    edge_t                  e;
    logic signed [CoordW:0] dx;
    logic [CoordW:0]        adx;
    dx    = $signed({1'b0, bx}) - $signed({1'b0, ax});
    adx   = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
    e.dy  = by - ay;
    e.n   = (adx[CoordW-1:0] > e.dy) ? adx[CoordW-1:0] : e.dy;
    e.x   = ax;
    e.y   = ay;
    e.rx  = {1'b0, e.n};
    e.ry  = {1'b0, e.n};
    e.dx  = dx;
    e.rem = e.n;
    e.exh = 1'b0;
    return e;
  endfunction

  // Advance one DDA point; caller guarantees rem > 0
  function automatic edge_t edge_step(edge_t e);
    edge_t                    r;
    logic signed [CoordW+2:0] tx;
    logic signed [CoordW+2:0] ty;
    logic signed [CoordW+2:0] n2;
    r  = e;
    n2 = $signed({2'b00, e.n, 1'b0});
    tx = $signed({2'b00, e.rx}) + $signed({e.dx[CoordW], e.dx, 1'b0});
    ty = $signed({2'b00, e.ry}) + $signed({2'b00, e.dy, 1'b0});
    if (tx >= n2) begin
      r.x  = e.x + 1'b1;
      r.rx = (CoordW+1)'(tx - n2);
    end else if (tx < 0) begin
      r.x  = e.x - 1'b1;
      r.rx = (CoordW+1)'(tx + n2);
    end else begin
      r.rx = tx[CoordW:0];
    end
    if (ty >= n2) begin
      r.y  = e.y + 1'b1;
      r.ry = (CoordW+1)'(ty - n2);
    end else begin
      r.ry = ty[CoordW:0];
    end
    r.rem = e.rem - 1'b1;
    return r;
  endfunction

endpackage

@@ hdl/filled_triangle_span_generator.sv @@
// Filled triangle span generator.
// Input channel (in_valid_i/in_ready_o) takes two kinds of transaction:
// a load (req_type 0) with three vertices and a fill color, and a span
// request (req_type 1). A load gives no result; each span request gives
// exactly one result on the output channel (out_valid_o/out_ready_i).
// Spans come top to bottom; last_span marks the final one. A span request
// with no active triangle returns span_valid 0 with all fields 0.
// A general load keeps the input busy through three sort steps, classify,
// one multiply, a restoring divide over the 22 numerator bits, the split
// point and edge setup. A flat-top or flat-bottom load skips the multiply,
// the divide and the split point. A span walks the points of both edges on
// that row: one shared DDA stepper walks the left edge then the right edge,
// one point a cycle. Crossing into the lower half adds a step for edge setup.
// in_ready_o is high only while the sequencer is idle. A finished result
// sits in the output register; if the receiver stalls, the next load still
// proceeds, and the next span waits to write its result until it is taken.
// Reset clears the control state: no triangle is active, the output is empty.
module filled_triangle_span_generator
  import ftsg_pkg::*;
#(
  parameter int unsigned CoordLimit = CoordLimitDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [CoordW-1:0] vx_a_i,
  input  logic [CoordW-1:0] vy_a_i,
  input  logic [CoordW-1:0] vx_b_i,
  input  logic [CoordW-1:0] vy_b_i,
  input  logic [CoordW-1:0] vx_c_i,
  input  logic [CoordW-1:0] vy_c_i,
  input  logic [ColorW-1:0] fill_red_i,
  input  logic [ColorW-1:0] fill_green_i,
  input  logic [ColorW-1:0] fill_blue_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] span_row_o,
  output logic [CoordW-1:0] span_x_start_o,
  output logic [CoordW-1:0] span_x_end_o,
  output logic [ColorW-1:0] out_red_o,
  output logic [ColorW-1:0] out_green_o,
  output logic [ColorW-1:0] out_blue_o,
  output logic              span_valid_o,
  output logic              last_span_o
);

  localparam logic [16:0]       CoordLim = 17'(CoordLimit);
  localparam logic [CoordW-1:0] CoordMax = CoordW'(CoordLimit - 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSort  = 4'd1;
  localparam logic [3:0] StClass = 4'd2;
  localparam logic [3:0] StPrep  = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StSplit = 4'd5;
  localparam logic [3:0] StInit  = 4'd6;
  localparam logic [3:0] StWalkL = 4'd7;
  localparam logic [3:0] StWalkR = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;
  localparam logic [3:0] StNull  = 4'd10;

  function automatic logic [CoordW-1:0] sat(logic [CoordW-1:0] v);
    return ({7'd0, v} >= CoordLim) ? CoordMax : v;
  endfunction

  logic [3:0]              state_q, state_d;
  logic [CoordW-1:0]       vx_q [3];
  logic [CoordW-1:0]       vy_q [3];
  logic [1:0]              sort_k_q;
  logic [3*ColorW-1:0]     colour_q;
  logic [CoordW-1:0]       split_q;
  logic [CoordW-1:0]       row_q;
  logic                    lower_q;
  logic                    active_q;
  logic signed [2*CoordW:0] prod_q;
  logic [DivNumW-1:0]      num_q;
  logic [DivDenW-1:0]      den_q;
  logic [DivDenW-1:0]      drem_q;
  logic [DivCntW-1:0]      dcnt_q;
  edge_t                   el_q, er_q;
  logic                    first_q;
  logic [CoordW-1:0]       xl_q, xr_q;

  logic                    out_valid_q;
  logic [CoordW-1:0]       o_row_q, o_xs_q, o_xe_q;
  logic [3*ColorW-1:0]     o_col_q;
  logic                    o_sv_q, o_last_q;

  logic in_acc;
  logic out_free;
  logic out_load;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == StEmit || state_q == StNull) && out_free;

  // Shared compare-swap for the sort
  logic [1:0] sa, sb;
  always_comb begin
    unique case (sort_k_q)
      2'd0:    begin sa = 2'd0; sb = 2'd1; end
      2'd1:    begin sa = 2'd0; sb = 2'd2; end
      default: begin sa = 2'd1; sb = 2'd2; end
    endcase
  end

  // Edge endpoints of the current half
  logic [CoordW-1:0] lm, rm;
  edge_t             el_init, er_init;
  always_comb begin
    lm = (split_q < vx_q[1]) ? split_q : vx_q[1];
    rm = (split_q < vx_q[1]) ? vx_q[1] : split_q;
    if (!lower_q) begin
      el_init = edge_init(vx_q[0], vy_q[0], lm, vy_q[1]);
      er_init = edge_init(vx_q[0], vy_q[0], rm, vy_q[1]);
    end else begin
      el_init = edge_init(lm, vy_q[1], vx_q[2], vy_q[2]);
      er_init = edge_init(rm, vy_q[1], vx_q[2], vy_q[2]);
    end
  end

  // Shared DDA stepper
  edge_t walk_e, walk_n;
  logic  walk_pend;
  always_comb begin
    walk_e    = (state_q == StWalkR) ? er_q : el_q;
    walk_n    = edge_step(walk_e);
    walk_pend = !walk_e.exh && (walk_e.y == row_q);
  end

  // Divider step
  logic [DivDenW:0] dtrial;
  logic             dge;
  assign dtrial = {drem_q, num_q[DivNumW-1]};
  assign dge    = dtrial >= {1'b0, den_q};

  logic signed [CoordW:0]   cdx;
  logic [CoordW-1:0]        cdy;
  logic [2*CoordW:0]        pabs;
  logic signed [CoordW+1:0] split_s;
  logic [CoordW-1:0]        end_row;
  logic [CoordW-1:0]        sp_lo, sp_hi;
  always_comb begin
    cdx     = $signed({1'b0, vx_q[2]}) - $signed({1'b0, vx_q[0]});
    cdy     = vy_q[1] - vy_q[0];
    pabs    = prod_q[2*CoordW] ? (2*CoordW+1)'(-prod_q) : (2*CoordW+1)'(prod_q);
    split_s = prod_q[2*CoordW] ?
              $signed({2'b00, vx_q[0]}) - $signed({2'b00, num_q[CoordW-1:0]}) :
              $signed({2'b00, vx_q[0]}) + $signed({2'b00, num_q[CoordW-1:0]});
    end_row = lower_q ? vy_q[2] : vy_q[1];
    sp_lo   = (xl_q > xr_q) ? xr_q : xl_q;
    sp_hi   = (xl_q > xr_q) ? xl_q : xr_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (req_type_i == ReqLoad) state_d = StSort;
          else if (active_q)         state_d = StWalkL;
          else                       state_d = StNull;
        end
      end
      StSort:  if (sort_k_q == 2'd2) state_d = StClass;
      StClass: begin
        if (vy_q[1] == vy_q[2] || vy_q[0] == vy_q[1]) state_d = StInit;
        else                                          state_d = StPrep;
      end
      StPrep:  state_d = StDiv;
      StDiv:   if (dcnt_q == DivCntW'(DivNumW - 1)) state_d = StSplit;
      StSplit: state_d = StInit;
      StInit:  state_d = StIdle;
      StWalkL: if (!walk_pend) state_d = StWalkR;
      StWalkR: if (!walk_pend) state_d = StEmit;
      StEmit: begin
        if (out_free) begin
          if (row_q >= end_row && !lower_q && vy_q[1] != vy_q[2]) state_d = StInit;
          else                                                     state_d = StIdle;
        end
      end
      StNull:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sort_k_q    <= 2'd0;
      dcnt_q      <= '0;
      active_q    <= 1'b0;
      lower_q     <= 1'b0;
      row_q       <= '0;
      split_q     <= '0;
      colour_q    <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          first_q <= 1'b1;
          if (in_acc && req_type_i == ReqLoad) begin
            active_q <= 1'b0;
            vx_q[0]  <= sat(vx_a_i);
            vy_q[0]  <= sat(vy_a_i);
            vx_q[1]  <= sat(vx_b_i);
            vy_q[1]  <= sat(vy_b_i);
            vx_q[2]  <= sat(vx_c_i);
            vy_q[2]  <= sat(vy_c_i);
            colour_q <= {fill_red_i, fill_green_i, fill_blue_i};
            sort_k_q <= 2'd0;
          end
        end
        StSort: begin
          if (vy_q[sa] > vy_q[sb]) begin
            vx_q[sa] <= vx_q[sb];
            vy_q[sa] <= vy_q[sb];
            vx_q[sb] <= vx_q[sa];
            vy_q[sb] <= vy_q[sa];
          end
          sort_k_q <= sort_k_q + 2'd1;
        end
        StClass: begin
          if (vy_q[1] == vy_q[2]) begin
            split_q <= vx_q[2];
            lower_q <= 1'b0;
          end else if (vy_q[0] == vy_q[1]) begin
            split_q <= vx_q[0];
            lower_q <= 1'b1;
          end else begin
            lower_q <= 1'b0;
          end
        end
        StPrep: begin
          num_q  <= DivNumW'({pabs, 1'b0}) + DivNumW'(vy_q[2] - vy_q[0]);
          den_q  <= {vy_q[2] - vy_q[0], 1'b0};
          drem_q <= '0;
          dcnt_q <= '0;
        end
        StDiv: begin
          drem_q <= dge ? DivDenW'(dtrial - {1'b0, den_q}) : dtrial[DivDenW-1:0];
          num_q  <= {num_q[DivNumW-2:0], dge};
          dcnt_q <= dcnt_q + 1'b1;
        end
        StSplit: split_q <= split_s[CoordW-1:0];
        StInit: begin
          row_q    <= lower_q ? vy_q[1] : vy_q[0];
          active_q <= 1'b1;
        end
        StWalkL, StWalkR: begin
          if (walk_pend) begin
            first_q <= 1'b0;
          end else begin
            first_q <= 1'b1;
          end
        end
        StEmit: begin
          if (out_free) begin
            if (row_q >= end_row) begin
              if (!lower_q && vy_q[1] != vy_q[2]) begin
                lower_q <= 1'b1;
              end else begin
                active_q <= 1'b0;
              end
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= cdx * $signed({1'b0, cdy});
    if (state_q == StInit) begin
      el_q <= el_init;
      er_q <= er_init;
    end
    if (state_q == StWalkL && walk_pend) begin
      if (first_q || walk_e.x < xl_q) xl_q <= walk_e.x;
      if (walk_e.rem == '0) el_q.exh <= 1'b1;
      else                  el_q     <= walk_n;
    end
    if (state_q == StWalkR && walk_pend) begin
      if (first_q || walk_e.x > xr_q) xr_q <= walk_e.x;
      if (walk_e.rem == '0) er_q.exh <= 1'b1;
      else                  er_q     <= walk_n;
    end
    if (state_q == StEmit && out_free) begin
      o_row_q  <= row_q;
      o_xs_q   <= sp_lo;
      o_xe_q   <= sp_hi;
      o_col_q  <= colour_q;
      o_sv_q   <= 1'b1;
      o_last_q <= (row_q >= end_row) && !(!lower_q && vy_q[1] != vy_q[2]);
    end
    if (state_q == StNull && out_free) begin
      o_row_q  <= '0;
      o_xs_q   <= '0;
      o_xe_q   <= '0;
      o_col_q  <= '0;
      o_sv_q   <= 1'b0;
      o_last_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_row_o     = o_row_q;
  assign span_x_start_o = o_xs_q;
  assign span_x_end_o   = o_xe_q;
  assign out_red_o      = o_col_q[3*ColorW-1:2*ColorW];
  assign out_green_o    = o_col_q[2*ColorW-1:ColorW];
  assign out_blue_o     = o_col_q[ColorW-1:0];
  assign span_valid_o   = o_sv_q;
  assign last_span_o    = o_last_q;

  a_walk_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalkL || state_q == StWalkR) |-> active_q)
    else $error("edge walk without an active triangle");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_sv_q) |-> (o_xs_q <= o_xe_q))
    else $error("span start above span end");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_last_q) |-> o_sv_q)
    else $error("last flag on an empty span");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (dcnt_q < DivCntW'(DivNumW)))
    else $error("divider count overrun");

endmodule

@@ tb/span_checker.sv @@
module span_checker
  import ftsg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              req_type_i,
  input  logic [CoordW-1:0] vx_a_i,
  input  logic [CoordW-1:0] vy_a_i,
  input  logic [CoordW-1:0] vx_b_i,
  input  logic [CoordW-1:0] vy_b_i,
  input  logic [CoordW-1:0] vx_c_i,
  input  logic [CoordW-1:0] vy_c_i,
  input  logic [ColorW-1:0] fill_red_i,
  input  logic [ColorW-1:0] fill_green_i,
  input  logic [ColorW-1:0] fill_blue_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CoordW-1:0] span_row_i,
  input  logic [CoordW-1:0] span_x_start_i,
  input  logic [CoordW-1:0] span_x_end_i,
  input  logic [ColorW-1:0] out_red_i,
  input  logic [ColorW-1:0] out_green_i,
  input  logic [ColorW-1:0] out_blue_i,
  input  logic              span_valid_i,
  input  logic              last_span_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                spans_seen_o,
  output int                lasts_seen_o
);

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] xs;
    logic [CoordW-1:0] xe;
    logic [ColorW-1:0] r;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] b;
    logic              sv;
    logic              last;
  } span_t;

  span_t expected_spans[$];

  longint vx[3], vy[3];
  longint split_x, cur_row, left_n, right_n;
  bit     lower, busy;
  logic [23:0] colour;

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint nsteps(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = absv(bx - ax);
    dy = absv(by - ay);
    return dx > dy ? dx : dy;
  endfunction

  // Endpoints of the left and right edge of the current half
  task automatic half_edges(output longint e[8]);
    longint lm, rm;
    lm = split_x < vx[1] ? split_x : vx[1];
    rm = split_x < vx[1] ? vx[1] : split_x;
    if (!lower) begin
      e = '{vx[0], vy[0], lm, vy[1], vx[0], vy[0], rm, vy[1]};
    end else begin
      e = '{lm, vy[1], vx[2], vy[2], rm, vy[1], vx[2], vy[2]};
    end
  endtask

  task automatic start_half();
    longint e[8];
    half_edges(e);
    left_n  = nsteps(e[0], e[1], e[2], e[3]);
    right_n = nsteps(e[4], e[5], e[6], e[7]);
  endtask

  task automatic walk_edge(input longint ax, ay, bx, by, n, row, bit want_max,
                           output bit found, output longint best);
    longint x, y;
    found = 0;
    best  = 0;
    for (longint i = 0; i <= n; i++) begin
      if (n == 0) begin
        x = ax;
        y = ay;
      end else begin
        x = (2 * (ax * n + (bx - ax) * i) + n) / (2 * n);
        y = (2 * (ay * n + (by - ay) * i) + n) / (2 * n);
      end
      if (y == row && (!found || (want_max ? x > best : x < best))) best = x;
      if (y == row) found = 1;
    end
  endtask

  task automatic load_triangle();
    longint p, d, q, tx, ty;
    vx = '{vx_a_i, vx_b_i, vx_c_i};
    vy = '{vy_a_i, vy_b_i, vy_c_i};
    for (int k = 0; k < 3; k++) begin
      int a, b;
      a = k == 2 ? 1 : 0;
      b = k == 0 ? 1 : 2;
      if (vy[a] > vy[b]) begin
        tx = vx[a]; ty = vy[a];
        vx[a] = vx[b]; vy[a] = vy[b];
        vx[b] = tx; vy[b] = ty;
      end
    end
    colour = {fill_red_i, fill_green_i, fill_blue_i};
    if (vy[1] == vy[2]) begin
      split_x = vx[2];
      lower = 0;
    end else if (vy[0] == vy[1]) begin
      split_x = vx[0];
      lower = 1;
    end else begin
      p = (vx[2] - vx[0]) * (vy[1] - vy[0]);
      d = vy[2] - vy[0];
      q = (2 * absv(p) + d) / (2 * d);
      if (p < 0) q = -q;
      split_x = (vx[0] + q) & 10'h3FF;
      lower = 0;
    end
    cur_row = lower ? vy[1] : vy[0];
    start_half();
    busy = 1;
  endtask

  task automatic predict_span();
    longint e[8];
    longint xl, xr, t, end_row;
    bit fl, fr;
    span_t s;
    s = '0;
    if (busy) begin
      half_edges(e);
      walk_edge(e[0], e[1], e[2], e[3], left_n, cur_row, 0, fl, xl);
      walk_edge(e[4], e[5], e[6], e[7], right_n, cur_row, 1, fr, xr);
      if (!fl) xl = fr ? xr : e[0];
      if (!fr) xr = xl;
      if (xl > xr) begin
        t = xl; xl = xr; xr = t;
      end
      s.row = cur_row[CoordW-1:0];
      s.xs  = xl[CoordW-1:0];
      s.xe  = xr[CoordW-1:0];
      {s.r, s.g, s.b} = colour;
      s.sv = 1;
      end_row = lower ? vy[2] : vy[1];
      if (cur_row >= end_row) begin
        if (!lower && vy[1] != vy[2]) begin
          lower = 1;
          cur_row = vy[1];
          start_half();
        end else begin
          s.last = 1;
          busy = 0;
        end
      end else begin
        cur_row++;
      end
    end
    expected_spans.insert(expected_spans.size(), s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    span_t got, want;
    if (!rst_ni) begin
      expected_spans.delete();
      busy = 0;
      fail_count_o <= 0;
      spans_seen_o <= 0;
      lasts_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{span_row_i, span_x_start_i, span_x_end_i, out_red_i, out_green_i,
                out_blue_i, span_valid_i, last_span_i};
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected span %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_spans.pop_front();
          if (got !== want) begin
            $display("%0t: span mismatch expected %p actual %p", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
          spans_seen_o <= spans_seen_o + 1;
          if (got.last) lasts_seen_o <= lasts_seen_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == ReqLoad) load_triangle();
        else predict_span();
      end
    end
  end

  assign pending_o = expected_spans.size();

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import ftsg_pkg::*;

  logic              clk, rst_n;
  logic              in_valid, in_ready, req_type;
  logic [CoordW-1:0] vx_a, vy_a, vx_b, vy_b, vx_c, vy_c;
  logic [ColorW-1:0] fill_r, fill_g, fill_b;
  logic              out_valid, out_ready;
  logic [CoordW-1:0] span_row, span_xs, span_xe;
  logic [ColorW-1:0] out_r, out_g, out_b;
  logic              span_valid, last_span;
  int                fails, pending, spans_seen, lasts_seen;
  int                cycles;
  int                items_sent;
  bit                hold_sink;

  filled_triangle_span_generator uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .vx_a_i(vx_a), .vy_a_i(vy_a), .vx_b_i(vx_b),
    .vy_b_i(vy_b), .vx_c_i(vx_c), .vy_c_i(vy_c), .fill_red_i(fill_r),
    .fill_green_i(fill_g), .fill_blue_i(fill_b), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .span_row_o(span_row), .span_x_start_o(span_xs),
    .span_x_end_o(span_xe), .out_red_o(out_r), .out_green_o(out_g),
    .out_blue_o(out_b), .span_valid_o(span_valid), .last_span_o(last_span)
  );

  span_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .vx_a_i(vx_a), .vy_a_i(vy_a), .vx_b_i(vx_b),
    .vy_b_i(vy_b), .vx_c_i(vx_c), .vy_c_i(vy_c), .fill_red_i(fill_r),
    .fill_green_i(fill_g), .fill_blue_i(fill_b), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .span_row_i(span_row), .span_x_start_i(span_xs),
    .span_x_end_i(span_xe), .out_red_i(out_r), .out_green_i(out_g),
    .out_blue_i(out_b), .span_valid_i(span_valid), .last_span_i(last_span),
    .fail_count_o(fails), .pending_o(pending), .spans_seen_o(spans_seen),
    .lasts_seen_o(lasts_seen)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send(logic kind, logic [CoordW-1:0] ax, ay, bx, by, cx, cy,
                      logic [ColorW-1:0] r, g, b);
    in_valid <= 1;
    req_type <= kind;
    vx_a <= ax; vy_a <= ay; vx_b <= bx; vy_b <= by; vx_c <= cx; vy_c <= cy;
    fill_r <= r; fill_g <= g; fill_b <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    in_valid <= 0;
    // Drop valid for the cycle after a transaction, while the block is busy
    @(posedge clk);
  endtask

  task automatic span_req(int gap);
    send(ReqSpan, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
         CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
         ColorW'($urandom), ColorW'($urandom), ColorW'($urandom));
    idle_cycles(gap);
  endtask

  task automatic load_tri(logic [CoordW-1:0] ax, ay, bx, by, cx, cy);
    send(ReqLoad, ax, ay, bx, by, cx, cy, ColorW'($urandom), ColorW'($urandom),
         ColorW'($urandom));
  endtask

  // Walk all spans of the loaded triangle, plus some extra
  task automatic drain_triangle(int gap_mode);
    int goal;
    goal = lasts_seen + 1;
    while (lasts_seen < goal && pending == 0 || pending != 0 && lasts_seen < goal) begin
      span_req(gap_mode ? gap_len() : 0);
      while (pending > 2) @(posedge clk);
    end
  endtask

  task automatic random_triangle(int scale);
    logic [CoordW-1:0] base_x, base_y;
    base_x = CoordW'($urandom);
    base_y = CoordW'($urandom);
    load_tri(base_x + CoordW'($urandom_range(0, scale)),
             base_y + CoordW'($urandom_range(0, scale)),
             base_x + CoordW'($urandom_range(0, scale)),
             base_y + CoordW'($urandom_range(0, scale)),
             base_x + CoordW'($urandom_range(0, scale)),
             base_y + CoordW'($urandom_range(0, scale)));
  endtask

  task automatic wait_empty();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    items_sent = 0;
    in_valid = 0; req_type = ReqSpan;
    {vx_a, vy_a, vx_b, vy_b, vx_c, vy_c} = '0;
    {fill_r, fill_g, fill_b} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // No triangle active yet
    span_req(0);
    span_req(0);
    // General split triangle, both lean directions
    load_tri(10, 2, 3, 9, 17, 14);
    drain_triangle(0);
    load_tri(3, 0, 20, 5, 1, 9);
    drain_triangle(0);
    // Flat bottom, flat top, single row, single point
    load_tri(5, 1, 12, 6, 1, 6);
    drain_triangle(0);
    load_tri(9, 4, 2, 4, 6, 8);
    drain_triangle(0);
    load_tri(1, 7, 30, 7, 12, 7);
    drain_triangle(0);
    load_tri(4, 4, 4, 4, 4, 4);
    drain_triangle(0);
    // Extremes of the coordinate range, shallow edges
    send(ReqLoad, 1023, 1020, 0, 1023, 1023, 1023, 8'hFF, 8'h00, 8'hFF);
    drain_triangle(0);
    send(ReqLoad, 0, 1021, 1023, 1022, 511, 1023, 8'h00, 8'hFF, 8'h00);
    drain_triangle(0);
    // Drop a triangle part way, then spans after it ends
    load_tri(0, 0, 8, 20, 3, 40);
    span_req(0);
    span_req(0);
    load_tri(2, 3, 6, 5, 1, 6);
    drain_triangle(0);
    span_req(0);
    wait_empty();

    // Let the sink stall while spans keep coming
    hold_sink = 1;
    load_tri(100, 100, 110, 108, 95, 115);
    for (int i = 0; i < 6; i++) span_req(0);
    hold_sink = 0;
    wait_empty();

    while (items_sent < 800) begin
      int kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // Noise: random spans and full-range vertices
        load_tri(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                 CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        repeat ($urandom_range(1, 5)) span_req(gap_len());
      end else begin
        random_triangle(kind < 4 ? 1023 : $urandom_range(1, 24));
        if (kind < 4) begin
          repeat ($urandom_range(2, 8)) span_req(gap_len());
        end else begin
          drain_triangle($urandom_range(0, 1));
        end
        idle_cycles(gap_len());
      end
      if (kind == 7) wait_empty();
    end
    wait_empty();
    idle_cycles(60);
    $display("Covered %0d spans over %0d finished triangles, incl. flat, split, degenerate",
             spans_seen, lasts_seen);
    $display("and full-range cases, with source gaps and sink stalls.");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Sink side: random stalls, plus a long hold-off while hold_sink is set
  initial begin
    int stall;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (stall > 0 && !hold_sink) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 10000000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
